// ===== design/cicu_pkg.sv =====
// shared types and constants for the common interval counter
package cicu_pkg;

   localparam int MAX_LEN_DEF = 256;
   localparam int DATA_W      = 16;
   localparam int COUNT_W     = 16;
   localparam int LEN_W       = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAP_RD,
      ST_MAP_SCAN,
      ST_CNT_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] value_a;
      logic [DATA_W-1:0] value_b;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] interval_count;
      logic [LEN_W-1:0]   seq_length;
      logic               overflow;
   } rsp_type;

endpackage

// ===== design/common_interval_counter_unit.sv =====
// common interval counter: loads two sequences, maps positions and counts common intervals
//
// Element pairs are taken at one item per cycle and written to two sequence memories.
// The item carrying last starts the computation, during which req_stall stays high.
// For n stored pairs the position map is built one element at a time: each element
// of the first sequence is fetched, and then the second sequence memory is
// scanned one entry per cycle through its single read port until the first match or the end.
// The interval count then sweeps the position map memory over every end position from
// x onward for each start position x. The result is then held on the rsp_ port
// until taken, after which a new sequence may be loaded. Pairs beyond MAX_LEN are
// dropped and flagged in the overflow field of the result.
module common_interval_counter_unit #(
   parameter int MAX_LEN = cicu_pkg::MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cicu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cicu_pkg::rsp_type rsp_payload
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);

   cicu_pkg::state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [cicu_pkg::COUNT_W-1:0] total_ff, total_in;

   logic                        seq_we;
   logic                        first_re;
   logic                        second_re;
   logic [cicu_pkg::DATA_W-1:0] first_rdata;
   logic [cicu_pkg::DATA_W-1:0] second_rdata;
   logic                        map_we;
   logic [CW-1:0]               map_wdata;
   logic                        map_re;
   logic [CW-1:0]               map_rdata;

   logic          issue;
   logic          hit;
   logic          first_y;
   logic [CW-1:0] lo_new;
   logic [CW-1:0] hi_new;
   logic [CW-1:0] i_next;
   logic [31:0]   len_wide;

   // sequence and position map memories
   cicu_ram #(.WIDTH(cicu_pkg::DATA_W), .DEPTH(MAX_LEN)) u_first_ram (
      .clock   (clock),
      .wr_en   (seq_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_payload.value_a),
      .rd_en   (first_re),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (first_rdata)
   );

   cicu_ram #(.WIDTH(cicu_pkg::DATA_W), .DEPTH(MAX_LEN)) u_second_ram (
      .clock   (clock),
      .wr_en   (seq_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_payload.value_b),
      .rd_en   (second_re),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (second_rdata)
   );

   cicu_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (i_ff[AW-1:0]),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (map_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cicu_pkg::ST_LOAD;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      pidx_ff  <= pidx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      total_ff <= total_in;
   end

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pend_in   = 1'b0;
      pidx_in   = j_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      total_in  = total_ff;
      seq_we    = 1'b0;
      first_re  = 1'b0;
      second_re = 1'b0;
      map_we    = 1'b0;
      map_wdata = fill_ff;
      map_re    = 1'b0;
      issue     = (j_ff != fill_ff);
      i_next    = CW'(i_ff + 1'b1);
      hit       = pend_ff && (second_rdata == first_rdata);
      first_y   = (pidx_ff == i_ff);
      lo_new    = (first_y || map_rdata < lo_ff) ? map_rdata : lo_ff;
      hi_new    = (first_y || map_rdata > hi_ff) ? map_rdata : hi_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         // store one pair per item
         cicu_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (fill_ff < CW'(MAX_LEN)) begin
                  seq_we  = 1'b1;
                  fill_in = CW'(fill_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last) begin
                  i_in     = '0;
                  j_in     = '0;
                  total_in = '0;
                  state_in = cicu_pkg::ST_MAP_RD;
               end
            end
         end

         // fetch element i of the first sequence
         cicu_pkg::ST_MAP_RD: begin
            first_re = 1'b1;
            j_in     = '0;
            state_in = cicu_pkg::ST_MAP_SCAN;
         end

         // scan the second sequence for the first match
         cicu_pkg::ST_MAP_SCAN: begin
            second_re = issue;
            pend_in   = issue;
            if (issue) begin
               j_in = CW'(j_ff + 1'b1);
            end
            if (hit || (pend_ff && !issue)) begin
               map_we    = 1'b1;
               map_wdata = hit ? pidx_ff : fill_ff;
               j_in      = '0;
               pend_in   = 1'b0;
               if (i_next == fill_ff) begin
                  i_in     = '0;
                  state_in = cicu_pkg::ST_CNT_SCAN;
               end else begin
                  i_in     = i_next;
                  state_in = cicu_pkg::ST_MAP_RD;
               end
            end
         end

         // sweep windows starting at i, one end position per cycle
         cicu_pkg::ST_CNT_SCAN: begin
            map_re  = issue;
            pend_in = issue;
            if (issue) begin
               j_in = CW'(j_ff + 1'b1);
            end
            if (pend_ff) begin
               lo_in = lo_new;
               hi_in = hi_new;
               if ((CW'(hi_new - lo_new) == CW'(pidx_ff - i_ff)) &&
                   (total_ff != cicu_pkg::COUNT_MAX)) begin
                  total_in = total_ff + 1'b1;
               end
               if (!issue) begin
                  if (i_next == fill_ff) begin
                     state_in = cicu_pkg::ST_OUT;
                  end else begin
                     i_in = i_next;
                     j_in = i_next;
                  end
               end
            end
         end

         // hold the result until taken
         cicu_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               fill_in  = '0;
               ovf_in   = 1'b0;
               state_in = cicu_pkg::ST_LOAD;
            end
         end

         default: begin
            state_in = cicu_pkg::ST_LOAD;
         end
      endcase
   end

   // result item
   always_comb begin
      len_wide = 32'(fill_ff);
      rsp_payload.interval_count = total_ff;
      rsp_payload.seq_length     = (len_wide > 32'(cicu_pkg::LEN_MAX)) ?
                                   cicu_pkg::LEN_MAX : len_wide[cicu_pkg::LEN_W-1:0];
      rsp_payload.overflow       = ovf_ff;
   end

endmodule

// ===== design/cicu_ram.sv =====
// generic single write port, single read port ram with registered read
module cicu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the common interval counter unit
module testbench;

   localparam int ITEMS_PLANNED = 1300;
   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTS   = 10;
   localparam int LIMIT_TIME    = 12_000_000;

   typedef enum {
      SEQ_SAME,
      SEQ_REVERSED,
      SEQ_PERMUTED,
      SEQ_DISJOINT,
      SEQ_FEW_VALUES,
      SEQ_WILD
   } seq_kind_type;

   typedef struct packed {
      cicu_pkg::req_type pair;
      logic              wait_empty;
   } pending_pair_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   cicu_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   cicu_pkg::rsp_type rsp_payload;

   // pairs waiting to be offered, and the predicted results not yet seen
   pending_pair_type  pair_backlog[$];
   pending_pair_type  next_pair;
   cicu_pkg::rsp_type interval_results[$];
   cicu_pkg::rsp_type oldest_result;

   // predictor copy of the stored sequences
   logic [cicu_pkg::DATA_W-1:0] seq_first[$];
   logic [cicu_pkg::DATA_W-1:0] seq_second[$];
   bit                          seq_overflow = 1'b0;

   int planned_items = ITEMS_PLANNED;
   int items_taken   = 0;
   int results_due   = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int hold_left     = 0;
   bit hold_go       = 1'b0;

   common_interval_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // window count over the first-occurrence positions in the second sequence of each element of the first
   function automatic cicu_pkg::rsp_type predict_intervals(
         input logic [cicu_pkg::DATA_W-1:0] fa[$],
         input logic [cicu_pkg::DATA_W-1:0] fb[$],
         input bit dropped);
      int                n;
      int                first_pos[$];
      int                lo;
      int                hi;
      int                total;
      cicu_pkg::rsp_type r;
      n = fa.size();
      total = 0;
      for (int i = 0; i < n; i++) begin
         int p;
         p = n;
         for (int j = 0; j < n; j++) begin
            if (fb[j] == fa[i]) begin
               p = j;
               break;
            end
         end
         first_pos = {first_pos, p};
      end
      for (int x = 0; x < n; x++) begin
         lo = first_pos[x];
         hi = lo;
         for (int y = x; y < n; y++) begin
            if (first_pos[y] < lo) lo = first_pos[y];
            if (first_pos[y] > hi) hi = first_pos[y];
            if (hi - lo == y - x && total < cicu_pkg::COUNT_MAX) total++;
         end
      end
      r.interval_count = total[cicu_pkg::COUNT_W-1:0];
      r.seq_length     = (n > cicu_pkg::LEN_MAX) ? cicu_pkg::LEN_MAX : cicu_pkg::LEN_W'(n);
      r.overflow       = dropped;
      return r;
   endfunction

   // idling share in percent for the current phase of the run
   function automatic int idle_pct(input bit receiver);
      if (items_taken < planned_items / 3) return receiver ? 86 : 18;
      if (items_taken < 2 * planned_items / 3) return receiver ? 18 : 86;
      return 0;
   endfunction

   task automatic queue_pair(input logic [cicu_pkg::DATA_W-1:0] a,
                             input logic [cicu_pkg::DATA_W-1:0] b,
                             input bit is_last, input bit wait_empty);
      pending_pair_type e;
      e.pair.value_a = a;
      e.pair.value_b = b;
      e.pair.last    = is_last;
      e.wait_empty   = wait_empty;
      pair_backlog = {pair_backlog, e};
   endtask

   task automatic queue_sequence(input int len, input seq_kind_type kind,
                                 input bit wait_first);
      logic [cicu_pkg::DATA_W-1:0] fa[$];
      logic [cicu_pkg::DATA_W-1:0] fb[$];
      logic [cicu_pkg::DATA_W-1:0] base;
      logic [cicu_pkg::DATA_W-1:0] step;
      logic [cicu_pkg::DATA_W-1:0] t;
      int                          k;
      base = 16'($urandom);
      step = 16'($urandom) | 16'd1;
      // odd stride keeps the progression free of repeats
      for (int i = 0; i < len; i++) begin
         case (kind)
            SEQ_FEW_VALUES: begin
               fa = {fa, 16'(base ^ 16'($urandom_range(7)))};
               fb = {fb, 16'(base ^ 16'($urandom_range(7)))};
            end
            SEQ_WILD: begin
               fa = {fa, 16'($urandom)};
               fb = {fb, 16'($urandom)};
            end
            SEQ_DISJOINT: begin
               fa = {fa, 16'(base + i * step)};
               fb = {fb, 16'(base + (i + len) * step)};
            end
            default: begin
               fa = {fa, 16'(base + i * step)};
               fb = {fb, 16'(base + i * step)};
            end
         endcase
      end
      if (kind == SEQ_REVERSED) begin
         for (int i = 0; i < len; i++) fb[i] = fa[len - 1 - i];
      end
      // shuffled second sequence with the odd element broken
      if (kind == SEQ_PERMUTED) begin
         for (int i = len - 1; i > 0; i--) begin
            k = $urandom_range(i);
            t = fb[i];
            fb[i] = fb[k];
            fb[k] = t;
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) fb[i] = 16'($urandom);
         end
      end
      for (int i = 0; i < len; i++) begin
         queue_pair(fa[i], fb[i], i == len - 1, wait_first && i == 0);
      end
   endtask

   task automatic queue_random_sequence();
      int           len;
      int           pick;
      seq_kind_type kind;
      len  = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      pick = $urandom_range(99);
      if (pick < 60) kind = SEQ_PERMUTED;
      else if (pick < 75) kind = SEQ_FEW_VALUES;
      else if (pick < 85) kind = SEQ_WILD;
      else if (pick < 90) kind = SEQ_SAME;
      else if (pick < 95) kind = SEQ_REVERSED;
      else kind = SEQ_DISJOINT;
      queue_sequence(len, kind, 1'b0);
   endtask

   // driver: offers pending pairs and updates the predictor on each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            items_taken <= items_taken + 1;
            if (seq_first.size() < cicu_pkg::MAX_LEN_DEF) begin
               seq_first  = {seq_first, req_payload.value_a};
               seq_second = {seq_second, req_payload.value_b};
            end else begin
               seq_overflow = 1'b1;
            end
            if (req_payload.last) begin
               interval_results = {interval_results,
                                   predict_intervals(seq_first, seq_second, seq_overflow)};
               results_due <= results_due + 1;
               seq_first.delete();
               seq_second.delete();
               seq_overflow = 1'b0;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pair_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0) &&
                (!pair_backlog[0].wait_empty ||
                 (results_due == results_seen &&
                  !(req_valid && !req_stall && req_payload.last)))) begin
               next_pair = pair_backlog.pop_front();
               req_payload <= next_pair.pair;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
   end

   // monitor: compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (interval_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: count %0d length %0d overflow %0d",
                        rsp_payload.interval_count, rsp_payload.seq_length,
                        rsp_payload.overflow);
         end else begin
            oldest_result = interval_results.pop_front();
            if (rsp_payload.interval_count !== oldest_result.interval_count ||
                rsp_payload.seq_length !== oldest_result.seq_length ||
                rsp_payload.overflow !== oldest_result.overflow) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           oldest_result.interval_count, oldest_result.seq_length,
                           oldest_result.overflow, rsp_payload.interval_count,
                           rsp_payload.seq_length, rsp_payload.overflow);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      // single-pair sequences, matched and unmatched, and a three-pair sequence, at the value extremes
      queue_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'hffff, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'h0000, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'hffff, 16'hffff, 1'b0, 1'b0);
      queue_pair(16'h8000, 16'h8000, 1'b1, 1'b0);
      queue_sequence(4, SEQ_REVERSED, 1'b0);
      queue_sequence(4, SEQ_DISJOINT, 1'b0);
      queue_sequence(5, SEQ_FEW_VALUES, 1'b0);
      queue_sequence(4, SEQ_WILD, 1'b0);
      // full store, largest possible count
      queue_sequence(cicu_pkg::MAX_LEN_DEF, SEQ_SAME, 1'b0);
      while (pair_backlog.size() < 700) queue_random_sequence();
      // overflow with last on a dropped pair, offered only once the block is empty
      queue_sequence(cicu_pkg::MAX_LEN_DEF + 2, SEQ_PERMUTED, 1'b1);
      while (pair_backlog.size() < ITEMS_PLANNED) queue_random_sequence();
      planned_items = pair_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < 2 * planned_items / 3) @(negedge clock);
      hold_go = 1'b1;
      @(negedge clock);
      hold_go = 1'b0;

      while (pair_backlog.size() != 0 || req_valid) @(negedge clock);
      while (results_seen != results_due || interval_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #LIMIT_TIME;
      $display("testbench failed");
      $finish;
   end

endmodule

// ===== common_interval_counter_unit.f =====
design/cicu_pkg.sv
design/cicu_ram.sv
design/common_interval_counter_unit.sv
tb/testbench.sv
